[sv/bemf_commutation_scheduler_unit_assert.svh]
// assertion macros for the commutation scheduler
`ifndef BEMF_COMMUTATION_SCHEDULER_UNIT_ASSERT_SVH
`define BEMF_COMMUTATION_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcs check failed");

// next-cycle implication, checked out of reset
`define BCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcs check failed");

`endif

[sv/bcs_pkg.sv]
// types and constants shared by the commutation scheduler modules
package bcs_pkg;

  typedef enum logic [1:0] {
    REQ_CROSSING = 2'd0,
    REQ_TIMER    = 2'd1,
    REQ_START    = 2'd2,
    REQ_STOP     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    IRQ_KEEP   = 2'd0,
    IRQ_MASK   = 2'd1,
    IRQ_ENABLE = 2'd2
  } irq_e;

  typedef enum logic [2:0] {
    CFG_ADVANCE_LEVEL   = 3'd0,
    CFG_AUTO_ADVANCE_ON = 3'd1,
    CFG_AUTO_LEVEL      = 3'd2,
    CFG_POLL_MODE       = 3'd3,
    CFG_STALL_BUDGET    = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [5:0]  AdvanceReset      = 6'd16;
  localparam logic [5:0]  AutoAdvanceReset  = 6'd16;
  localparam logic [15:0] StallBudgetReset  = 16'd20000;

  localparam logic [13:0] TrendMinCrossings    = 14'd20;
  localparam logic [13:0] DeadlineMinCrossings = 14'd100;
  localparam logic [13:0] CrossingCountCap     = 14'd10000;
  localparam logic [15:0] DemagMinInterval     = 16'd500;
  localparam logic [15:0] StartInterval        = 16'd10000;
  localparam logic [15:0] StartTimer           = 16'd5000;
  localparam logic [16:0] HandoffExtra         = 17'd1000;
  localparam logic [16:0] StaleMargin          = 17'd4;
  localparam logic [7:0]  DemagRunMax          = 8'd255;

  typedef struct packed {
    logic [5:0]  advance_level;
    logic        auto_advance_on;
    logic [5:0]  auto_level;
    logic        poll_mode;
    logic [15:0] stall_budget;
  } cfg_t;

  typedef struct packed {
    req_e        req_type;
    logic [15:0] timer_count;
    logic        pre_level_seen;
  } item_t;

  // declared msb first so the packed struct is the output tdata word
  typedef struct packed {
    logic [7:0]  demag_late_run;
    logic        average_tainted;
    logic [16:0] predicted_interval;
    logic [15:0] interval_estimate;
    logic [15:0] wait_time;
    logic        stall_handoff;
    irq_e        phase_irq_ctrl;
    logic [15:0] interval_value;
    logic        interval_set;
    logic [15:0] com_timer_load;
    logic        com_timer_arm;
    logic        commutate_now;
  } res_t;

endpackage

[sv/bemf_commutation_scheduler_unit.sv]
// top level of the sensorless commutation scheduler
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata timer fields, tuser req_type
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata 96-bit result
//   cfg       in         cfg_we_i                       cfg_index_i, cfg_wdata_i
//
// a request accepted into the input register has its result registered in the output
// register after one pass through the update logic; one request per cycle is sustained
// while m_axis_tready is high, the state update of a request completing in that single pass
// reset clears valid flags and loads configuration and state defaults; no clearing pass
// a stalled result holds in the output register while the next request waits
// in the input register
`include "bemf_commutation_scheduler_unit_assert.svh"

module bemf_commutation_scheduler_unit
  import bcs_pkg::*;
#(
  parameter int unsigned TAINT_LENGTH = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // [15:0] timer_count, [16] pre_level_seen
  input  logic [1:0]          s_axis_tuser,   // [1:0] req_type
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] commutate_now, [1] com_timer_arm, [17:2] com_timer_load, [18] interval_set,
  // [34:19] interval_value, [36:35] phase_irq_ctrl, [37] stall_handoff,
  // [53:38] wait_time, [69:54] interval_estimate, [86:70] predicted_interval,
  // [87] average_tainted, [95:88] demag_late_run
  output logic [95:0]         m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  fire;
  res_t  res;
  logic  out_valid_q;
  res_t  res_q;

  assign fire = item_valid && (!out_valid_q || m_axis_tready);

  bcs_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bcs_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pop_i         (fire),
    .valid_o       (item_valid),
    .item_o        (item)
  );

  bcs_core #(
    .TAINT_LENGTH (TAINT_LENGTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

  `BCS_ASSERT_NEXT(a_fire_fills_output, fire, out_valid_q)
  `BCS_ASSERT_NEXT(a_waiting_request_held, item_valid && !fire, item_valid && $stable(item))
  `BCS_ASSERT_NOW(a_handoff_masks_irq, out_valid_q && res_q.stall_handoff,
                  res_q.interval_set && res_q.phase_irq_ctrl == IRQ_MASK)
  `BCS_ASSERT_NOW(a_sighted_commutation_enables_irq,
                  out_valid_q && res_q.commutate_now && !res_q.interval_set,
                  res_q.phase_irq_ctrl == IRQ_ENABLE)

endmodule

[sv/bcs_cfg_regs.sv]
// configuration registers written through the plain write port
module bcs_cfg_regs
  import bcs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ADVANCE_LEVEL:   cfg_d.advance_level   = cfg_wdata_i[5:0];
        CFG_AUTO_ADVANCE_ON: cfg_d.auto_advance_on = cfg_wdata_i[0];
        CFG_AUTO_LEVEL:      cfg_d.auto_level      = cfg_wdata_i[5:0];
        CFG_POLL_MODE:       cfg_d.poll_mode       = cfg_wdata_i[0];
        CFG_STALL_BUDGET:    cfg_d.stall_budget    = cfg_wdata_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.advance_level   <= AdvanceReset;
      cfg_q.auto_advance_on <= 1'b0;
      cfg_q.auto_level      <= AutoAdvanceReset;
      cfg_q.poll_mode       <= 1'b0;
      cfg_q.stall_budget    <= StallBudgetReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/bcs_in_reg.sv]
// input register for event requests
module bcs_in_reg
  import bcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // timer_count, pre_level_seen, zero fill
  input  logic [1:0]  s_axis_tuser,   // req_type
  input  logic        pop_i,
  output logic        valid_o,
  output item_t       item_o
);

  logic  valid_q;
  item_t item_q;
  logic  load;

  assign s_axis_tready = !valid_q || pop_i;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.req_type       <= req_e'(s_axis_tuser);
      item_q.timer_count    <= s_axis_tdata[15:0];
      item_q.pre_level_seen <= s_axis_tdata[16];
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[sv/bcs_core.sv]
// scheduler state and the single-pass update for one event
module bcs_core
  import bcs_pkg::*;
#(
  parameter int unsigned TAINT_LENGTH = 12
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  localparam int unsigned TaintW = $clog2(TAINT_LENGTH + 1);

  logic               running_q, running_d;
  logic               armed_q, armed_d;
  logic               pre_seen_q, pre_seen_d;
  logic [31:0]        blind_q, blind_d;
  logic [15:0]        avg_q, avg_d;
  logic [15:0]        prev_q, prev_d;
  logic [15:0]        this_q, this_d;
  logic signed [17:0] trend_q, trend_d;
  logic [16:0]        pred_q, pred_d;
  logic [15:0]        wait_q, wait_d;
  logic [TaintW-1:0]  taint_q, taint_d;
  logic [13:0]        ccount_q, ccount_d;
  logic [7:0]         demag_q, demag_d;

  logic               timer_live, over_budget, blind_c;
  logic [16:0]        zc_sum, avg_sum;
  logic [15:0]        avg_upd, avg_go;
  logic signed [18:0] step_s, diff_s, trend_sum_s;
  logic signed [17:0] trend_go, lim_s, corr_s, pred_sum_s;
  logic [16:0]        pred_go;
  logic [5:0]         lvl;
  logic [22:0]        prod;
  logic [16:0]        adv, half;
  logic [15:0]        wait_go, dl_base;
  logic [16:0]        dl;
  logic [16:0]        wait_inc, budget_ext, stale_lhs;
  logic [32:0]        blind_sum;
  logic               stale;

  assign timer_live  = running_q && !cfg_i.poll_mode;
  assign over_budget = blind_q >= {16'd0, cfg_i.stall_budget};
  assign blind_c     = timer_live && armed_q && !over_budget;

  // averaged interval and trend, skipped on a blind commutation
  assign zc_sum  = {1'b0, prev_q} + {1'b0, this_q};
  assign avg_sum = {1'b0, avg_q} + {1'b0, zc_sum[16:1]};
  assign avg_upd = avg_sum[16:1];
  assign step_s  = $signed({3'b000, this_q}) - $signed({3'b000, prev_q});
  assign diff_s  = step_s - 19'(trend_q);
  assign trend_sum_s = 19'(trend_q) + (diff_s >>> 2);

  assign avg_go   = blind_c ? avg_q : avg_upd;
  assign trend_go = blind_c ? trend_q : trend_sum_s[17:0];

  // trend correction clamped to half the average
  assign lim_s = $signed({3'b000, avg_go[15:1]});
  always_comb begin
    if (trend_go > lim_s) begin
      corr_s = lim_s;
    end else if (trend_go < -lim_s) begin
      corr_s = -lim_s;
    end else begin
      corr_s = trend_go;
    end
  end
  assign pred_sum_s = $signed({2'b00, avg_go}) + corr_s;
  assign pred_go    = (ccount_q >= TrendMinCrossings) ? pred_sum_s[16:0] : {1'b0, avg_go};

  assign lvl  = cfg_i.auto_advance_on ? cfg_i.auto_level : cfg_i.advance_level;
  assign prod = pred_go * lvl;
  assign adv  = prod[22:6];
  assign half = {1'b0, pred_go[16:1]};
  assign wait_go = (half > adv) ? 16'(half - adv) : 16'd0;

  // crossing deadline at about one and a half intervals
  assign dl_base = (avg_go >= wait_go) ? (avg_go - wait_go) : 16'd0;
  assign dl      = {1'b0, dl_base} + {2'b00, avg_go[15:1]};

  assign wait_inc   = {1'b0, wait_q} + 17'd1;
  assign budget_ext = {1'b0, cfg_i.stall_budget} + HandoffExtra;
  assign stale_lhs  = {1'b0, item_i.timer_count} + StaleMargin;
  assign stale      = stale_lhs < {1'b0, wait_q};
  assign blind_sum  = {1'b0, blind_q} + {17'd0, item_i.timer_count};

  always_comb begin
    running_d  = running_q;
    armed_d    = armed_q;
    pre_seen_d = pre_seen_q;
    blind_d    = blind_q;
    avg_d      = avg_q;
    prev_d     = prev_q;
    this_d     = this_q;
    trend_d    = trend_q;
    pred_d     = pred_q;
    wait_d     = wait_q;
    taint_d    = taint_q;
    ccount_d   = ccount_q;
    demag_d    = demag_q;
    res_o                = '0;
    res_o.phase_irq_ctrl = IRQ_KEEP;

    case (item_i.req_type)
      REQ_CROSSING: begin
        res_o.phase_irq_ctrl = IRQ_MASK;
        armed_d = 1'b0;
        if (avg_q > DemagMinInterval && !pre_seen_q && !item_i.pre_level_seen) begin
          if (demag_q < DemagRunMax) begin
            demag_d = demag_q + 8'd1;
          end
        end else begin
          demag_d = '0;
        end
        pre_seen_d = 1'b0;
        blind_d    = '0;
        prev_d     = this_q;
        this_d     = item_i.timer_count;
        res_o.interval_set   = 1'b1;
        res_o.com_timer_arm  = 1'b1;
        res_o.com_timer_load = wait_inc[16] ? 16'hFFFF : wait_inc[15:0];
      end
      REQ_TIMER: begin
        if (!timer_live) begin
          armed_d = 1'b0;
        end else if (armed_q && over_budget) begin
          armed_d = 1'b0;
          res_o.phase_irq_ctrl = IRQ_MASK;
          res_o.interval_set   = 1'b1;
          res_o.interval_value = budget_ext[16] ? 16'hFFFF : budget_ext[15:0];
          res_o.stall_handoff  = 1'b1;
        end else if (!armed_q && stale) begin
          // cancelled deadline fired early: re-arm for the remainder
          res_o.com_timer_arm  = 1'b1;
          res_o.com_timer_load = wait_q - item_i.timer_count;
        end else begin
          res_o.commutate_now  = 1'b1;
          res_o.phase_irq_ctrl = IRQ_ENABLE;
          armed_d = 1'b0;
          if (blind_c) begin
            res_o.interval_set = 1'b1;
            blind_d = blind_sum[32] ? 32'hFFFF_FFFF : blind_sum[31:0];
          end
          avg_d   = avg_go;
          trend_d = trend_go;
          pred_d  = pred_go;
          wait_d  = wait_go;
          if (ccount_q >= DeadlineMinCrossings) begin
            armed_d = 1'b1;
            res_o.com_timer_arm  = 1'b1;
            res_o.com_timer_load = dl[16] ? 16'hFFFF : dl[15:0];
          end
          if (blind_c) begin
            taint_d = TaintW'(TAINT_LENGTH);
          end else if (taint_q != '0) begin
            taint_d = taint_q - 1'b1;
          end
          if (!blind_c && ccount_q < CrossingCountCap) begin
            ccount_d = ccount_q + 14'd1;
          end
        end
      end
      REQ_START: begin
        if (!running_q) begin
          armed_d    = 1'b0;
          blind_d    = '0;
          taint_d    = '0;
          trend_d    = '0;
          pred_d     = '0;
          pre_seen_d = 1'b1;
          demag_d    = '0;
          avg_d      = StartInterval;
          running_d  = 1'b1;
          res_o.commutate_now  = 1'b1;
          res_o.interval_set   = 1'b1;
          res_o.interval_value = StartTimer;
        end
        res_o.phase_irq_ctrl = IRQ_ENABLE;
      end
      REQ_STOP: begin
        running_d = 1'b0;
        armed_d   = 1'b0;
        ccount_d  = '0;
        res_o.phase_irq_ctrl = IRQ_MASK;
      end
      default: begin
        res_o.phase_irq_ctrl = IRQ_KEEP;
      end
    endcase

    res_o.wait_time          = wait_d;
    res_o.interval_estimate  = avg_d;
    res_o.predicted_interval = pred_d;
    res_o.average_tainted    = taint_d != '0;
    res_o.demag_late_run     = demag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      armed_q    <= 1'b0;
      pre_seen_q <= 1'b1;
      blind_q    <= '0;
      avg_q      <= StartInterval;
      prev_q     <= '0;
      this_q     <= '0;
      trend_q    <= '0;
      pred_q     <= '0;
      wait_q     <= '0;
      taint_q    <= '0;
      ccount_q   <= '0;
      demag_q    <= '0;
    end else if (fire_i) begin
      running_q  <= running_d;
      armed_q    <= armed_d;
      pre_seen_q <= pre_seen_d;
      blind_q    <= blind_d;
      avg_q      <= avg_d;
      prev_q     <= prev_d;
      this_q     <= this_d;
      trend_q    <= trend_d;
      pred_q     <= pred_d;
      wait_q     <= wait_d;
      taint_q    <= taint_d;
      ccount_q   <= ccount_d;
      demag_q    <= demag_d;
    end
  end

endmodule

[test/tb_bemf_commutation_scheduler_unit.sv]
// self-checking testbench for the sensorless commutation scheduler, predictor and scoreboard
module tb_bemf_commutation_scheduler_unit;
  import bcs_pkg::*;

  localparam int unsigned TaintSpan  = 12;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned NumPhases  = 5;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [15:0] timer_count, [16] pre_level_seen
  logic [1:0]  s_axis_tuser;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [0] commutate_now, [1] com_timer_arm, [17:2] com_timer_load, [18] interval_set,
  // [34:19] interval_value, [36:35] phase_irq_ctrl, [37] stall_handoff,
  // [53:38] wait_time, [69:54] interval_estimate, [86:70] predicted_interval,
  // [87] average_tainted, [95:88] demag_late_run
  logic [95:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  bemf_commutation_scheduler_unit #(
    .TAINT_LENGTH(TaintSpan)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // scheduler state as the testbench sees it
  cfg_t        cfg_m;
  logic        running, dl_armed, pre_seen;
  logic [31:0] blind_acc;
  logic [15:0] avg_iv, zc_prev, zc_last, wait_t;
  int          trend_v;
  logic [16:0] pred_iv;
  logic [3:0]  taint_left;
  logic [13:0] cross_n;
  logic [7:0]  demag_n;

  item_t req_backlog[$];
  res_t  sched_expect[$];

  bit          req_taken;
  bit          steady_flow;
  int unsigned stuck_cycles;
  int unsigned errors, n_reqs, n_checked, n_settings;
  int unsigned n_handoff, n_blind, n_stale, peak_demag;

  function automatic logic [15:0] clip16(int unsigned v);
    return (v > 32'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic item_t mk(req_e kind, int unsigned tc, logic pre);
    item_t it;
    it.req_type       = kind;
    it.timer_count    = tc[15:0];
    it.pre_level_seen = pre;
    return it;
  endfunction

  task automatic predict_schedule(input item_t it, output res_t r);
    int unsigned tc, a, mid, p, lvl, adv, half, dl;
    int          st, lim, corr;
    logic        blind, go;
    tc    = it.timer_count;
    r     = '0;
    blind = 1'b0;
    go    = 1'b1;
    r.phase_irq_ctrl = IRQ_KEEP;
    case (it.req_type)
      REQ_CROSSING: begin
        r.phase_irq_ctrl = IRQ_MASK;
        dl_armed = 1'b0;
        if (avg_iv > DemagMinInterval && !pre_seen && !it.pre_level_seen) begin
          if (demag_n != DemagRunMax) demag_n++;
        end else begin
          demag_n = '0;
        end
        pre_seen  = 1'b0;
        blind_acc = '0;
        zc_prev   = zc_last;
        zc_last   = it.timer_count;
        r.interval_set   = 1'b1;
        r.com_timer_arm  = 1'b1;
        r.com_timer_load = clip16(int'(wait_t) + 1);
      end
      REQ_TIMER: begin
        if (!running || cfg_m.poll_mode) begin
          dl_armed = 1'b0;
          go = 1'b0;
        end else if (dl_armed) begin
          dl_armed = 1'b0;
          if (blind_acc >= cfg_m.stall_budget) begin
            r.phase_irq_ctrl = IRQ_MASK;
            r.interval_set   = 1'b1;
            r.interval_value = clip16(int'(cfg_m.stall_budget) + HandoffExtra);
            r.stall_handoff  = 1'b1;
            go = 1'b0;
            n_handoff++;
          end else begin
            blind = 1'b1;
            r.phase_irq_ctrl = IRQ_MASK;
            blind_acc = (blind_acc > 32'hFFFF_FFFF - tc) ? 32'hFFFF_FFFF : blind_acc + tc;
            r.interval_set = 1'b1;
            n_blind++;
          end
        end else if (tc + StaleMargin < wait_t) begin
          // cancelled deadline raced the crossing: re-arm with what is left
          r.com_timer_arm  = 1'b1;
          r.com_timer_load = wait_t - tc[15:0];
          go = 1'b0;
          n_stale++;
        end
        if (go) begin
          r.commutate_now = 1'b1;
          if (!blind) begin
            st     = int'(zc_last) - int'(zc_prev);
            a      = zc_prev;
            mid    = zc_last;
            mid    = (a + mid) >> 1;
            a      = avg_iv;
            avg_iv = (a + mid) >> 1;
            trend_v = trend_v + ((st - trend_v) >>> 2);
          end
          p = avg_iv;
          if (cross_n >= TrendMinCrossings) begin
            lim  = avg_iv >> 1;
            corr = trend_v;
            if (corr > lim) corr = lim;
            else if (corr < -lim) corr = -lim;
            p = int'(avg_iv) + corr;
          end
          pred_iv = p[16:0];
          lvl  = cfg_m.auto_advance_on ? cfg_m.auto_level : cfg_m.advance_level;
          adv  = (p * lvl) >> 6;
          half = p >> 1;
          wait_t = clip16(half > adv ? half - adv : 0);
          r.phase_irq_ctrl = IRQ_ENABLE;
          if (cross_n >= DeadlineMinCrossings) begin
            // crossing deadline loaded at the commutation: one and a half intervals less the wait time
            dl = (avg_iv >= wait_t) ? avg_iv - wait_t : 0;
            dl = dl + (avg_iv >> 1);
            dl_armed = 1'b1;
            r.com_timer_arm  = 1'b1;
            r.com_timer_load = clip16(dl);
          end
          if (blind) taint_left = TaintSpan & 15;
          else if (taint_left != 0) taint_left--;
          if (!blind && cross_n < CrossingCountCap) cross_n++;
        end
      end
      REQ_START: begin
        if (!running) begin
          dl_armed   = 1'b0;
          blind_acc  = '0;
          taint_left = '0;
          trend_v    = 0;
          pred_iv    = '0;
          pre_seen   = 1'b1;
          demag_n    = '0;
          avg_iv     = StartInterval;
          running    = 1'b1;
          r.commutate_now  = 1'b1;
          r.interval_set   = 1'b1;
          r.interval_value = StartTimer;
        end
        r.phase_irq_ctrl = IRQ_ENABLE;
      end
      default: begin
        running  = 1'b0;
        dl_armed = 1'b0;
        cross_n  = '0;
        r.phase_irq_ctrl = IRQ_MASK;
      end
    endcase
    r.wait_time          = wait_t;
    r.interval_estimate  = avg_iv;
    r.predicted_interval = pred_iv;
    r.average_tainted    = (taint_left != 0);
    r.demag_late_run     = demag_n;
    if (demag_n > peak_demag) peak_demag = demag_n;
  endtask

  task automatic check_field(string what, logic [16:0] want, logic [16:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
    end
  endtask

  // sampled at the rising edge, before the block's registers move
  always @(posedge clk_i) begin : monitor
    res_t  got, want;
    item_t it;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata);
        if (sched_expect.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none got %h", $time, m_axis_tdata);
        end else begin
          want = sched_expect.pop_front();
          n_checked++;
          check_field("commutate_now", want.commutate_now, got.commutate_now);
          check_field("com_timer_arm", want.com_timer_arm, got.com_timer_arm);
          check_field("com_timer_load", want.com_timer_load, got.com_timer_load);
          check_field("interval_set", want.interval_set, got.interval_set);
          check_field("interval_value", want.interval_value, got.interval_value);
          check_field("phase_irq_ctrl", want.phase_irq_ctrl, got.phase_irq_ctrl);
          check_field("stall_handoff", want.stall_handoff, got.stall_handoff);
          check_field("wait_time", want.wait_time, got.wait_time);
          check_field("interval_estimate", want.interval_estimate, got.interval_estimate);
          check_field("predicted_interval", want.predicted_interval, got.predicted_interval);
          check_field("average_tainted", want.average_tainted, got.average_tainted);
          check_field("demag_late_run", want.demag_late_run, got.demag_late_run);
        end
      end
      req_taken = s_axis_tvalid && s_axis_tready;
      if (req_taken) begin
        it.req_type       = req_e'(s_axis_tuser);
        it.timer_count    = s_axis_tdata[15:0];
        it.pre_level_seen = s_axis_tdata[16];
        predict_schedule(it, want);
        sched_expect.push_back(want);
        n_reqs++;
      end
      if (req_taken || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles = 0;
      end else if (++stuck_cycles >= StuckLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, stuck_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // inputs move on the falling edge only
  always @(negedge clk_i) begin : driver
    item_t it;
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      if (req_backlog.size() != 0 && (steady_flow || $urandom_range(99, 0) >= 33)) begin
        it = req_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, it.pre_level_seen, it.timer_count};
        s_axis_tuser  <= it.req_type;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    if (rst_ni) m_axis_tready <= steady_flow || ($urandom_range(99, 0) >= 33);
  end

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val[15:0];
    @(negedge clk_i);
  endtask

  task automatic set_config(int unsigned adv, int unsigned auto_on, int unsigned auto_lvl,
                            int unsigned poll, int unsigned budget);
    write_reg(CFG_ADVANCE_LEVEL, adv);
    write_reg(CFG_AUTO_ADVANCE_ON, auto_on);
    write_reg(CFG_AUTO_LEVEL, auto_lvl);
    write_reg(CFG_POLL_MODE, poll);
    write_reg(CFG_STALL_BUDGET, budget);
    cfg_we_i <= 1'b0;
    cfg_m.advance_level   = adv[5:0];
    cfg_m.auto_advance_on = auto_on[0];
    cfg_m.auto_level      = auto_lvl[5:0];
    cfg_m.poll_mode       = poll[0];
    cfg_m.stall_budget    = budget[15:0];
    n_settings++;
  endtask

  // start, then mostly crossing/timer pairs around one interval, with blind bursts,
  // stale timer fires and stray requests mixed in; usually ends with a stop
  task automatic queue_traffic(int unsigned amount);
    int unsigned first, base, k, j, n, pick, lo, hi;
    first = req_backlog.size();
    while (req_backlog.size() - first < amount) begin
      req_backlog.push_back(mk(REQ_START, $urandom_range(65535, 0), $urandom_range(1, 0)));
      pick = $urandom_range(9, 0);
      if (pick == 0) base = $urandom_range(600, 100);
      else if (pick == 1) base = $urandom_range(65535, 40000);
      else base = $urandom_range(30000, 1000);
      lo = base - base / 8;
      hi = base + base / 8;
      if (hi > 65535) hi = 65535;
      k = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(170, 120);
      for (j = 0; j < k; j++) begin
        pick = $urandom_range(99, 0);
        if (pick < 78) begin
          req_backlog.push_back(mk(REQ_CROSSING, $urandom_range(hi, lo),
                                   $urandom_range(9, 0) != 0));
          req_backlog.push_back(mk(REQ_TIMER, $urandom_range(65535, base),
                                   $urandom_range(1, 0)));
        end else if (pick < 88) begin
          n = $urandom_range(5, 1);
          repeat (n)
            req_backlog.push_back(mk(REQ_TIMER, $urandom_range(65535, 0),
                                     $urandom_range(1, 0)));
        end else if (pick < 92) begin
          req_backlog.push_back(mk(REQ_TIMER, $urandom_range(15, 0), $urandom_range(1, 0)));
        end else begin
          req_backlog.push_back(mk(req_e'($urandom_range(2, 0)), $urandom_range(65535, 0),
                                   $urandom_range(1, 0)));
        end
      end
      if ($urandom_range(3, 0) != 0)
        req_backlog.push_back(mk(REQ_STOP, $urandom_range(65535, 0), $urandom_range(1, 0)));
    end
  endtask

  initial begin : stimulus
    int unsigned ph;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_CROSSING;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_ADVANCE_LEVEL;
    cfg_wdata_i   = '0;
    steady_flow   = 1'b0;

    cfg_m.advance_level   = AdvanceReset;
    cfg_m.auto_advance_on = 1'b0;
    cfg_m.auto_level      = AutoAdvanceReset;
    cfg_m.poll_mode       = 1'b0;
    cfg_m.stall_budget    = StallBudgetReset;
    running    = 1'b0;
    dl_armed   = 1'b0;
    pre_seen   = 1'b1;
    blind_acc  = '0;
    avg_iv     = StartInterval;
    zc_prev    = '0;
    zc_last    = '0;
    trend_v    = 0;
    pred_iv    = '0;
    wait_t     = '0;
    taint_left = '0;
    cross_n    = '0;
    demag_n    = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: crossings and timer fires while stopped, demag-late crossings,
    // double start, stale timer fire, stop and restart
    req_backlog.push_back(mk(REQ_CROSSING, 0, 1'b0));
    req_backlog.push_back(mk(REQ_CROSSING, 65535, 1'b0));
    req_backlog.push_back(mk(REQ_CROSSING, 1, 1'b1));
    req_backlog.push_back(mk(REQ_TIMER, 65535, 1'b1));
    req_backlog.push_back(mk(REQ_STOP, 0, 1'b0));
    req_backlog.push_back(mk(REQ_START, 65535, 1'b1));
    req_backlog.push_back(mk(REQ_START, 0, 1'b0));
    req_backlog.push_back(mk(REQ_CROSSING, 30000, 1'b1));
    req_backlog.push_back(mk(REQ_TIMER, 0, 1'b0));
    req_backlog.push_back(mk(REQ_TIMER, 0, 1'b1));
    req_backlog.push_back(mk(REQ_TIMER, 4, 1'b0));
    req_backlog.push_back(mk(REQ_TIMER, 65535, 1'b1));
    req_backlog.push_back(mk(REQ_CROSSING, 65535, 1'b0));
    req_backlog.push_back(mk(REQ_CROSSING, 12345, 1'b0));
    req_backlog.push_back(mk(REQ_TIMER, 32768, 1'b1));
    req_backlog.push_back(mk(REQ_STOP, 65535, 1'b1));
    req_backlog.push_back(mk(REQ_TIMER, 100, 1'b0));
    req_backlog.push_back(mk(REQ_CROSSING, 0, 1'b1));
    req_backlog.push_back(mk(REQ_START, 21845, 1'b0));
    req_backlog.push_back(mk(REQ_STOP, 43690, 1'b1));

    for (ph = 0; ph < NumPhases; ph++) begin
      do @(negedge clk_i);
      while (req_backlog.size() != 0 || sched_expect.size() != 0 || s_axis_tvalid);
      case (ph)
        0: set_config(16, 0, 16, 0, 20000);
        1: set_config(63, 0, 0, 0, 0);
        2: set_config(0, 1, 63, 0, 65535);
        3: set_config(0, 1, 0, 0, 3000);
        4: set_config(40, 0, 5, 1, 1000);
        default: set_config($urandom_range(63, 0), $urandom_range(1, 0), $urandom_range(63, 0),
                            $urandom_range(5, 0) == 0, $urandom_range(65535, 0));
      endcase
      steady_flow = (ph == 2);
      if (ph == 0) begin
        // long unbroken demag-late run to push the counter into saturation
        req_backlog.push_back(mk(REQ_START, 0, 1'b1));
        repeat (260)
          req_backlog.push_back(mk(REQ_CROSSING, $urandom_range(65535, 0), 1'b0));
        req_backlog.push_back(mk(REQ_STOP, 0, 1'b0));
      end
      queue_traffic(230);
    end

    do @(negedge clk_i);
    while (req_backlog.size() != 0 || sched_expect.size() != 0 || s_axis_tvalid);
    repeat (8) @(posedge clk_i);

    $display("%0d requests over %0d register settings, %0d results checked",
             n_reqs, n_settings, n_checked);
    $display("stall handoffs %0d, blind commutations %0d, stale re-arms %0d, peak demag run %0d",
             n_handoff, n_blind, n_stale, peak_demag);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
